// ===== hdl/jtt_pkg.sv =====
`timescale 1ns / 1ps

package jtt_pkg;

    localparam int POSITION_BITS_DEFAULT = 24;
    localparam int OUT_POS_W = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_STR  = 3'd1;
    localparam logic [2:0] MODE_ESC  = 3'd2;
    localparam logic [2:0] MODE_NUM  = 3'd3;
    localparam logic [2:0] MODE_WORD = 3'd4;
    localparam logic [2:0] MODE_ERR  = 3'd5;

    localparam logic [1:0] EV_CONTENT = 2'd0;
    localparam logic [1:0] EV_TOKEN   = 2'd1;
    localparam logic [1:0] EV_ERROR   = 2'd2;
    localparam logic [1:0] EV_DONE    = 2'd3;

    localparam logic [3:0] KIND_STRING   = 4'd0;
    localparam logic [3:0] KIND_FLOAT    = 4'd1;
    localparam logic [3:0] KIND_NULL     = 4'd2;
    localparam logic [3:0] KIND_COMMA    = 4'd3;
    localparam logic [3:0] KIND_LBRACE   = 4'd4;
    localparam logic [3:0] KIND_RBRACE   = 4'd5;
    localparam logic [3:0] KIND_LBRACKET = 4'd6;
    localparam logic [3:0] KIND_RBRACKET = 4'd7;
    localparam logic [3:0] KIND_COLON    = 4'd8;
    localparam logic [3:0] KIND_INTEGER  = 4'd9;
    localparam logic [3:0] KIND_BOOL     = 4'd10;

    localparam logic [2:0] ERR_BAD_ESC       = 3'd0;
    localparam logic [2:0] ERR_UNTERMINATED  = 3'd1;
    localparam logic [2:0] ERR_TRAILING_DOT  = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN_WORD  = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN_BYTE  = 3'd4;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CASE_BIT     = 8'h20;

    localparam logic [39:0] KW_TRUE  = 40'h0074727565;
    localparam logic [39:0] KW_NULL  = 40'h006E756C6C;
    localparam logic [39:0] KW_FALSE = 40'h66616C7365;

    typedef struct packed {
        logic [1:0]           ev;
        logic [3:0]           kind;
        logic [7:0]           data;
        logic [2:0]           err;
        logic [OUT_POS_W-1:0] line;
        logic [OUT_POS_W-1:0] col;
    } result_t;

    typedef struct packed {
        result_t res;
        logic    last;
    } entry_t;

    function automatic result_t make_result(
        input logic [1:0]           ev,
        input logic [3:0]           kind,
        input logic [7:0]           data,
        input logic [2:0]           err,
        input logic [OUT_POS_W-1:0] line,
        input logic [OUT_POS_W-1:0] col
    );
        result_t r;
        r.ev   = ev;
        r.kind = kind;
        r.data = data;
        r.err  = err;
        r.line = line;
        r.col  = col;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        logic [7:0] l;
        l = b | CASE_BIT;
        return (l >= CH_LOWER_A) && (l <= CH_LOWER_Z);
    endfunction

endpackage

// ===== hdl/json_text_tokenizer.sv =====
`timescale 1ns / 1ps

// channel  | valid     | stall     | payload
// ---------+-----------+-----------+------------------------------------------------
// input    | in_valid  | in_stall  | text_byte, end_of_text
// output   | out_valid | out_stall | event_res, token_kind, data_byte, error_code,
//          |           |           | line_number, column, last
//
// one byte per cycle while each byte yields at most one event and out_stall stays low;
// after a byte that yields two or three events, the next byte waits in the input
// register while the result queue drains, one event per cycle unless out_stall is high
// an accepted byte passes through the input register and then the result queue before its first event shows
// rst_n is asynchronous; no clearing pass, the block takes bytes right after reset
// in_stall rises when the input register holds a byte and the queue has more than
// one event waiting

module json_text_tokenizer
    import jtt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           text_byte,
    input  logic                 end_of_text,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           event_res,
    output logic [3:0]           token_kind,
    output logic [7:0]           data_byte,
    output logic [2:0]           error_code,
    output logic [OUT_POS_W-1:0] line_number,
    output logic [OUT_POS_W-1:0] column,
    output logic                 last
);

    localparam int EXT_W = (POSITION_BITS > OUT_POS_W) ? POSITION_BITS : OUT_POS_W;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    function automatic logic [OUT_POS_W-1:0] to_out(input logic [POSITION_BITS-1:0] p);
        logic [EXT_W-1:0] e;
        e = EXT_W'(p);
        return e[OUT_POS_W-1:0];
    endfunction

    logic                     in_full_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_eot_reg;

    logic [2:0]               mode_reg,    mode_next;
    logic                     seen_reg,    seen_next;
    logic                     dot_reg,     dot_next;
    logic [39:0]              letters_reg, letters_next;
    logic [2:0]               len_reg,     len_next;
    logic                     long_reg,    long_next;
    logic [POSITION_BITS-1:0] wstart_reg,  wstart_next;
    logic [POSITION_BITS-1:0] line_reg,    line_next;
    logic [POSITION_BITS-1:0] col_reg,     col_next;

    result_t                  res_next [3];
    logic [1:0]               res_cnt;

    entry_t                   queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]        wr_ptr_reg;
    logic [QPTR_W-1:0]        rd_ptr_reg;
    logic [QCNT_W-1:0]        count_reg;

    logic                     proc;
    logic                     pop;

    assign proc     = in_full_reg && (count_reg <= QCNT_W'(QUEUE_DEPTH - 3));
    assign in_stall = in_full_reg && !proc;
    assign out_valid = (count_reg != '0);
    assign pop      = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_full_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= text_byte;
            in_eot_reg  <= end_of_text;
        end
    end

    always_comb
    begin
        logic [7:0]               b;
        logic [POSITION_BITS-1:0] col;
        logic [OUT_POS_W-1:0]     line_o;
        logic                     to_idle;
        logic                     newline;
        logic                     esc_ok;
        logic                     esc_u;
        logic [7:0]               esc_val;

        b       = in_byte_reg;
        col     = col_reg;
        line_o  = to_out(line_reg);
        to_idle = 1'b0;
        newline = 1'b0;
        esc_ok  = 1'b1;
        esc_u   = 1'b0;
        esc_val = 8'd0;
        res_cnt = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            res_next[i] = '0;
        end

        mode_next    = mode_reg;
        seen_next    = seen_reg;
        dot_next     = dot_reg;
        letters_next = letters_reg;
        len_next     = len_reg;
        long_next    = long_reg;
        wstart_next  = wstart_reg;
        line_next    = line_reg;
        col_next     = col_reg;

        unique case (b)
            CH_LOWER_N:   esc_val = CH_NEWLINE;
            CH_LOWER_R:   esc_val = CH_RETURN;
            CH_LOWER_T:   esc_val = CH_TAB;
            CH_LOWER_B:   esc_val = CH_BACKSPACE;
            CH_BACKSLASH: esc_val = CH_BACKSLASH;
            CH_QUOTE:     esc_val = CH_QUOTE;
            CH_LOWER_U:   esc_u   = 1'b1;
            default:      esc_ok  = 1'b0;
        endcase

        unique case (mode_reg)
            MODE_ERR:
            begin
            end
            MODE_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    res_next[res_cnt] = make_result(EV_TOKEN, KIND_STRING, 8'd0, 3'd0,
                                                    '0, '0);
                    res_cnt = res_cnt + 2'd1;
                    mode_next = MODE_IDLE;
                end
                else if (in_eot_reg)
                begin
                    res_next[res_cnt] = make_result(EV_ERROR, 4'd0, 8'd0,
                                                    ERR_UNTERMINATED, line_o, to_out(col));
                    res_cnt = res_cnt + 2'd1;
                    mode_next = MODE_ERR;
                end
                else if (b == CH_BACKSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    res_next[res_cnt] = make_result(EV_CONTENT, 4'd0, b, 3'd0, '0, '0);
                    res_cnt = res_cnt + 2'd1;
                end
            end
            MODE_ESC:
            begin
                if (!esc_ok)
                begin
                    res_next[res_cnt] = make_result(EV_ERROR, 4'd0, 8'd0, ERR_BAD_ESC,
                                                    line_o, to_out(col));
                    res_cnt = res_cnt + 2'd1;
                    mode_next = MODE_ERR;
                end
                else if (in_eot_reg)
                begin
                    res_next[res_cnt] = make_result(EV_ERROR, 4'd0, 8'd0,
                                                    ERR_UNTERMINATED, line_o, to_out(col));
                    res_cnt = res_cnt + 2'd1;
                    mode_next = MODE_ERR;
                end
                else
                begin
                    if (esc_u)
                    begin
                        res_next[res_cnt] = make_result(EV_CONTENT, 4'd0, CH_BACKSLASH,
                                                        3'd0, '0, '0);
                        res_cnt = res_cnt + 2'd1;
                        res_next[res_cnt] = make_result(EV_CONTENT, 4'd0, CH_LOWER_U,
                                                        3'd0, '0, '0);
                        res_cnt = res_cnt + 2'd1;
                    end
                    else
                    begin
                        res_next[res_cnt] = make_result(EV_CONTENT, 4'd0, esc_val,
                                                        3'd0, '0, '0);
                        res_cnt = res_cnt + 2'd1;
                    end
                    mode_next = MODE_STR;
                end
            end
            MODE_NUM:
            begin
                if (is_digit(b))
                begin
                    dot_next = 1'b0;
                end
                else if (b == CH_DOT && !seen_next)
                begin
                    seen_next = 1'b1;
                    dot_next  = 1'b1;
                end
                else
                begin
                    if (dot_next)
                    begin
                        res_next[res_cnt] = make_result(EV_ERROR, 4'd0, 8'd0,
                                                        ERR_TRAILING_DOT, line_o, to_out(col));
                        res_cnt = res_cnt + 2'd1;
                        mode_next = MODE_ERR;
                    end
                    else
                    begin
                        res_next[res_cnt] = make_result(EV_TOKEN,
                                                        seen_next ? KIND_FLOAT : KIND_INTEGER,
                                                        8'd0, 3'd0, '0, '0);
                        res_cnt = res_cnt + 2'd1;
                        mode_next = MODE_IDLE;
                        to_idle   = 1'b1;
                    end
                end
            end
            MODE_WORD:
            begin
                if (is_letter(b))
                begin
                    if (len_next >= 3'd5)
                    begin
                        long_next = 1'b1;
                    end
                    else
                    begin
                        letters_next = {letters_next[31:0], b};
                        len_next     = len_next + 3'd1;
                    end
                end
                else
                begin
                    if (!long_next && len_next == 3'd4 && letters_next == KW_TRUE)
                    begin
                        res_next[res_cnt] = make_result(EV_TOKEN, KIND_BOOL, 8'd1, 3'd0,
                                                        '0, '0);
                        res_cnt = res_cnt + 2'd1;
                        mode_next = MODE_IDLE;
                        to_idle   = 1'b1;
                    end
                    else if (!long_next && len_next == 3'd5 && letters_next == KW_FALSE)
                    begin
                        res_next[res_cnt] = make_result(EV_TOKEN, KIND_BOOL, 8'd0, 3'd0,
                                                        '0, '0);
                        res_cnt = res_cnt + 2'd1;
                        mode_next = MODE_IDLE;
                        to_idle   = 1'b1;
                    end
                    else if (!long_next && len_next == 3'd4 && letters_next == KW_NULL)
                    begin
                        res_next[res_cnt] = make_result(EV_TOKEN, KIND_NULL, 8'd0, 3'd0,
                                                        '0, '0);
                        res_cnt = res_cnt + 2'd1;
                        mode_next = MODE_IDLE;
                        to_idle   = 1'b1;
                    end
                    else
                    begin
                        res_next[res_cnt] = make_result(EV_ERROR, 4'd0, 8'd0,
                                                        ERR_UNKNOWN_WORD, line_o,
                                                        to_out(wstart_next));
                        res_cnt = res_cnt + 2'd1;
                        mode_next = MODE_ERR;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                to_idle   = 1'b1;
            end
        endcase

        if (to_idle)
        begin
            case (b)
                CH_QUOTE:
                begin
                    mode_next = MODE_STR;
                end
                CH_COMMA, CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_COLON:
                begin
                    res_next[res_cnt].ev = EV_TOKEN;
                    case (b)
                        CH_COMMA:    res_next[res_cnt].kind = KIND_COMMA;
                        CH_LBRACE:   res_next[res_cnt].kind = KIND_LBRACE;
                        CH_RBRACE:   res_next[res_cnt].kind = KIND_RBRACE;
                        CH_LBRACKET: res_next[res_cnt].kind = KIND_LBRACKET;
                        CH_RBRACKET: res_next[res_cnt].kind = KIND_RBRACKET;
                        default:     res_next[res_cnt].kind = KIND_COLON;
                    endcase
                    res_cnt = res_cnt + 2'd1;
                end
                CH_NEWLINE:
                begin
                    newline = 1'b1;
                end
                CH_SPACE, CH_TAB, CH_RETURN:
                begin
                end
                default:
                begin
                    if (is_digit(b))
                    begin
                        mode_next = MODE_NUM;
                        seen_next = 1'b0;
                        dot_next  = 1'b0;
                    end
                    else if (is_letter(b))
                    begin
                        mode_next    = MODE_WORD;
                        letters_next = {32'd0, b};
                        len_next     = 3'd1;
                        long_next    = 1'b0;
                        wstart_next  = col;
                    end
                    else
                    begin
                        res_next[res_cnt] = make_result(EV_ERROR, 4'd0, 8'd0,
                                                        ERR_UNKNOWN_BYTE, line_o, to_out(col));
                        res_cnt = res_cnt + 2'd1;
                        mode_next = MODE_ERR;
                    end
                end
            endcase
        end

        if (in_eot_reg)
        begin
            if (mode_next == MODE_NUM)
            begin
                if (dot_next)
                begin
                    res_next[res_cnt] = make_result(EV_ERROR, 4'd0, 8'd0,
                                                    ERR_TRAILING_DOT, line_o, to_out(col));
                end
                else
                begin
                    res_next[res_cnt] = make_result(EV_TOKEN,
                                                    seen_next ? KIND_FLOAT : KIND_INTEGER,
                                                    8'd0, 3'd0, '0, '0);
                end
                res_cnt = res_cnt + 2'd1;
            end
            else if (mode_next == MODE_WORD)
            begin
                if (!long_next && len_next == 3'd4 && letters_next == KW_TRUE)
                begin
                    res_next[res_cnt] = make_result(EV_TOKEN, KIND_BOOL, 8'd1, 3'd0,
                                                    '0, '0);
                end
                else if (!long_next && len_next == 3'd5 && letters_next == KW_FALSE)
                begin
                    res_next[res_cnt] = make_result(EV_TOKEN, KIND_BOOL, 8'd0, 3'd0,
                                                    '0, '0);
                end
                else if (!long_next && len_next == 3'd4 && letters_next == KW_NULL)
                begin
                    res_next[res_cnt] = make_result(EV_TOKEN, KIND_NULL, 8'd0, 3'd0,
                                                    '0, '0);
                end
                else
                begin
                    res_next[res_cnt] = make_result(EV_ERROR, 4'd0, 8'd0,
                                                    ERR_UNKNOWN_WORD, line_o,
                                                    to_out(wstart_next));
                end
                res_cnt = res_cnt + 2'd1;
            end
            else if (mode_next == MODE_STR || mode_next == MODE_ESC)
            begin
                res_next[res_cnt] = make_result(EV_ERROR, 4'd0, 8'd0, ERR_UNTERMINATED,
                                                line_o, to_out(col));
                res_cnt = res_cnt + 2'd1;
            end
            res_next[res_cnt] = make_result(EV_DONE, 4'd0, 8'd0, 3'd0, '0, '0);
            res_cnt = res_cnt + 2'd1;

            mode_next    = MODE_IDLE;
            seen_next    = 1'b0;
            dot_next     = 1'b0;
            letters_next = '0;
            len_next     = 3'd0;
            long_next    = 1'b0;
            wstart_next  = '0;
            line_next    = POSITION_BITS'(1);
            col_next     = '0;
        end
        else if (newline)
        begin
            if (line_reg != POS_MAX)
            begin
                line_next = line_reg + POSITION_BITS'(1);
            end
            col_next = '0;
        end
        else if (mode_next != MODE_ERR)
        begin
            if (col_reg != POS_MAX)
            begin
                col_next = col_reg + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            seen_reg    <= 1'b0;
            dot_reg     <= 1'b0;
            letters_reg <= '0;
            len_reg     <= 3'd0;
            long_reg    <= 1'b0;
            wstart_reg  <= '0;
            line_reg    <= POSITION_BITS'(1);
            col_reg     <= '0;
        end
        else if (proc)
        begin
            mode_reg    <= mode_next;
            seen_reg    <= seen_next;
            dot_reg     <= dot_next;
            letters_reg <= letters_next;
            len_reg     <= len_next;
            long_reg    <= long_next;
            wstart_reg  <= wstart_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
        end
    end

    // result queue, up to three writes per transaction
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < res_cnt)
                begin
                    queue_reg[wr_ptr_reg + QPTR_W'(i)].res  <= res_next[i];
                    queue_reg[wr_ptr_reg + QPTR_W'(i)].last <= (2'(i) == res_cnt - 2'd1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (proc)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(res_cnt);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + (proc ? QCNT_W'(res_cnt) : QCNT_W'(0))
                         - (pop ? QCNT_W'(1) : QCNT_W'(0));
        end
    end

    assign event_res   = queue_reg[rd_ptr_reg].res.ev;
    assign token_kind  = queue_reg[rd_ptr_reg].res.kind;
    assign data_byte   = queue_reg[rd_ptr_reg].res.data;
    assign error_code  = queue_reg[rd_ptr_reg].res.err;
    assign line_number = queue_reg[rd_ptr_reg].res.line;
    assign column      = queue_reg[rd_ptr_reg].res.col;
    assign last        = queue_reg[rd_ptr_reg].last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !proc |=> in_full_reg && $stable(in_byte_reg))
        else $error("held input byte lost");

    a_text_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_eot_reg |=> mode_reg == MODE_IDLE && line_reg == POSITION_BITS'(1)
                               && col_reg == '0)
        else $error("state not cleared after end of text");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_DONE |-> last)
        else $error("text done event not marked last");

endmodule
